/* sv/doubly_linked_list_with_cursor_core_assert.svh */
// Assertion macros for the doubly linked list core checker.
// Depends on nothing; included by the checker file.
`ifndef DOUBLY_LINKED_LIST_WITH_CURSOR_CORE_ASSERT_SVH
`define DOUBLY_LINKED_LIST_WITH_CURSOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define DLLC_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed in list core checker");

// Next-cycle implication, sampled on the rising clock edge.
`define DLLC_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed in list core checker");

`endif

/* sv/dllc_pkg.sv */
// Package for the doubly linked list core: word types, request codes,
// status codes and controller command/status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dllc_pkg;

    localparam int COUNT_W = 9;

    // Request codes.
    localparam logic [4:0] OP_CLEAR      = 5'd0;
    localparam logic [4:0] OP_INS_FIRST  = 5'd1;
    localparam logic [4:0] OP_INS_LAST   = 5'd2;
    localparam logic [4:0] OP_CUR_FIRST  = 5'd3;
    localparam logic [4:0] OP_CUR_LAST   = 5'd4;
    localparam logic [4:0] OP_RD_FIRST   = 5'd5;
    localparam logic [4:0] OP_RD_LAST    = 5'd6;
    localparam logic [4:0] OP_DEL_FIRST  = 5'd7;
    localparam logic [4:0] OP_DEL_LAST   = 5'd8;
    localparam logic [4:0] OP_DEL_AFTER  = 5'd9;
    localparam logic [4:0] OP_DEL_BEFORE = 5'd10;
    localparam logic [4:0] OP_INS_AFTER  = 5'd11;
    localparam logic [4:0] OP_INS_BEFORE = 5'd12;
    localparam logic [4:0] OP_RD_CUR     = 5'd13;
    localparam logic [4:0] OP_WR_CUR     = 5'd14;
    localparam logic [4:0] OP_STEP_FWD   = 5'd15;
    localparam logic [4:0] OP_STEP_BACK  = 5'd16;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [4:0]         req_type;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0]   read_value;
        logic [1:0]           status;
        logic                 cursor_active;
        logic [COUNT_W-1:0]   element_count;
    } rsp_t;

    // Phase commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rd2;
        logic cap;
        logic w1;
        logic w2;
        logic sweep;
        logic clear_done;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_clear;
    } sts_t;

endpackage

`default_nettype wire

/* sv/dllc_ctrl.sv */
// Controller for the doubly linked list core: phase sequencer and pool sweep.
// Depends on dllc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dllc_ctrl
    import dllc_pkg::*;
#(
    parameter int POOL_DEPTH = 256
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  sts_t                                       sts,
    output cmd_t                                       cmd,
    output logic [$clog2(POOL_DEPTH+1)-1:0]            sweep_idx,
    output logic                                       busy,
    output logic                                       done
);

    localparam int IW = $clog2(POOL_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(POOL_DEPTH - 1);
    localparam logic [IW-1:0] ONE = IW'(1);

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD1   = 3'd2;
    localparam logic [2:0] S_RD2   = 3'd3;
    localparam logic [2:0] S_CAP   = 3'd4;
    localparam logic [2:0] S_W1    = 3'd5;
    localparam logic [2:0] S_W2    = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          clr_reg, clr_next;
    logic          done_reg, done_next;

    // Next state and phase commands.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                idx_next  = idx_reg + ONE;
                if (idx_reg == LAST_IDX)
                begin
                    cmd.clear_done = clr_reg;
                    done_next      = clr_reg;
                    clr_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (sts.req_clear)
                    begin
                        idx_next   = '0;
                        clr_next   = 1'b1;
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_RD1;
                    end
                end
            end
            S_RD1: state_next = S_RD2;
            S_RD2:
            begin
                cmd.rd2    = 1'b1;
                state_next = S_CAP;
            end
            S_CAP:
            begin
                cmd.cap    = 1'b1;
                state_next = S_W1;
            end
            S_W1:
            begin
                cmd.w1     = 1'b1;
                state_next = S_W2;
            end
            S_W2:
            begin
                cmd.w2     = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            idx_reg   <= '0;
            clr_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    assign sweep_idx = idx_reg;
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;

endmodule

`default_nettype wire

/* sv/dllc_datapath.sv */
// Datapath for the doubly linked list core: node pool memories, list
// pointers and per-request link updates. Depends on dllc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dllc_datapath
    import dllc_pkg::*;
#(
    parameter int POOL_DEPTH = 256
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  req_t                                req,
    input  cmd_t                                cmd,
    input  wire logic [$clog2(POOL_DEPTH+1)-1:0] sweep_idx,
    output sts_t                                sts,
    output rsp_t                                result
);

    localparam int IW = $clog2(POOL_DEPTH + 1);
    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam logic [IW-1:0] NIL = IW'(POOL_DEPTH);
    localparam logic [IW-1:0] ONE = IW'(1);

    // Pool memories.
    logic [IW-1:0] next_mem [POOL_DEPTH];
    logic [IW-1:0] prev_mem [POOL_DEPTH];
    logic [31:0]   val_mem  [POOL_DEPTH];

    logic [IW-1:0] next_q, prev_q;
    logic [31:0]   val_q;
    logic          rnil_reg;

    logic          next_we, prev_we, val_we;
    logic [IW-1:0] next_wa, prev_wa, val_wa;
    logic [IW-1:0] next_wd, prev_wd;
    logic [31:0]   val_wd;
    logic [IW-1:0] raddr, a1, a2;

    // Request and list state.
    logic [4:0]    op_reg;
    logic [31:0]   v_reg;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] fh_reg, fh_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] d1_next_reg, d1_prev_reg, d2_next_reg, d2_prev_reg;
    logic [31:0]   d1_val_reg;
    rsp_t          result_reg;

    logic [IW-1:0] rd_next, rd_prev;
    logic [31:0]   rd_val;
    logic [31:0]   rv;
    logic [1:0]    st;
    logic          full, c_nil;
    logic [IW-1:0] cnt_dec;

    assign sts.req_clear = (req.req_type == OP_CLEAR);

    // Read data, with a null address reading as the null marker.
    assign rd_next = rnil_reg ? NIL : next_q;
    assign rd_prev = rnil_reg ? NIL : prev_q;
    assign rd_val  = rnil_reg ? 32'd0 : val_q;

    // First read address picks the node the request starts from.
    always_comb
    begin
        case (op_reg)
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AFTER, OP_INS_BEFORE: a1 = fh_reg;
            OP_RD_FIRST, OP_DEL_FIRST:                              a1 = head_reg;
            OP_RD_LAST, OP_DEL_LAST:                                a1 = tail_reg;
            default:                                                a1 = cur_reg;
        endcase
    end

    // Second read address follows a link from the first read or the cursor.
    always_comb
    begin
        case (op_reg)
            OP_DEL_AFTER:  a2 = rd_next;
            OP_DEL_BEFORE: a2 = rd_prev;
            default:       a2 = cur_reg;
        endcase
    end

    assign raddr = cmd.rd2 ? a2 : a1;

    // Memory ports.
    always_ff @(posedge clk)
    begin
        if (next_we && (next_wa < NIL))
            next_mem[next_wa[AW-1:0]] <= next_wd;
        if (prev_we && (prev_wa < NIL))
            prev_mem[prev_wa[AW-1:0]] <= prev_wd;
        if (val_we && (val_wa < NIL))
            val_mem[val_wa[AW-1:0]] <= val_wd;
        next_q   <= next_mem[raddr[AW-1:0]];
        prev_q   <= prev_mem[raddr[AW-1:0]];
        val_q    <= val_mem[raddr[AW-1:0]];
        rnil_reg <= (raddr >= NIL);
    end

    assign full    = (fh_reg == NIL);
    assign c_nil   = (cur_reg == NIL);
    assign cnt_dec = (cnt_reg != '0) ? (cnt_reg - ONE) : cnt_reg;

    // Per-request link writes and pointer updates.
    always_comb
    begin
        next_we   = 1'b0;
        prev_we   = 1'b0;
        val_we    = 1'b0;
        next_wa   = NIL;
        prev_wa   = NIL;
        val_wa    = NIL;
        next_wd   = NIL;
        prev_wd   = NIL;
        val_wd    = v_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        cur_next  = cur_reg;
        fh_next   = fh_reg;
        cnt_next  = cnt_reg;
        rv        = 32'd0;
        st        = ST_OK;
        case (op_reg)
            OP_INS_FIRST:
            begin
                if (full)
                    st = ST_FULL;
                else
                begin
                    if (cmd.w1)
                    begin
                        val_we  = 1'b1; val_wa  = fh_reg;
                        next_we = 1'b1; next_wa = fh_reg; next_wd = head_reg;
                        prev_we = 1'b1; prev_wa = fh_reg; prev_wd = NIL;
                    end
                    if (cmd.w2 && (head_reg != NIL))
                    begin
                        prev_we = 1'b1; prev_wa = head_reg; prev_wd = fh_reg;
                    end
                    fh_next  = d1_next_reg;
                    cnt_next = cnt_reg + ONE;
                    if (head_reg == NIL)
                        tail_next = fh_reg;
                    head_next = fh_reg;
                end
            end
            OP_INS_LAST:
            begin
                if (full)
                    st = ST_FULL;
                else
                begin
                    if (cmd.w1)
                    begin
                        val_we  = 1'b1; val_wa  = fh_reg;
                        next_we = 1'b1; next_wa = fh_reg; next_wd = NIL;
                        prev_we = 1'b1; prev_wa = fh_reg; prev_wd = tail_reg;
                    end
                    if (cmd.w2 && (tail_reg != NIL))
                    begin
                        next_we = 1'b1; next_wa = tail_reg; next_wd = fh_reg;
                    end
                    fh_next  = d1_next_reg;
                    cnt_next = cnt_reg + ONE;
                    if (tail_reg == NIL)
                        head_next = fh_reg;
                    tail_next = fh_reg;
                end
            end
            OP_CUR_FIRST: cur_next = head_reg;
            OP_CUR_LAST:  cur_next = tail_reg;
            OP_RD_FIRST:
            begin
                if (head_reg == NIL) st = ST_EMPTY;
                else                 rv = d1_val_reg;
            end
            OP_RD_LAST:
            begin
                if (tail_reg == NIL) st = ST_EMPTY;
                else                 rv = d1_val_reg;
            end
            OP_RD_CUR:
            begin
                if (c_nil) st = ST_EMPTY;
                else       rv = d1_val_reg;
            end
            OP_DEL_FIRST:
            begin
                if (head_reg != NIL)
                begin
                    if (cur_reg == head_reg)
                        cur_next = NIL;
                    if (head_reg == tail_reg)
                    begin
                        head_next = NIL;
                        tail_next = NIL;
                    end
                    else
                    begin
                        head_next = d1_next_reg;
                        if (cmd.w1)
                        begin
                            prev_we = 1'b1; prev_wa = d1_next_reg; prev_wd = NIL;
                        end
                    end
                    if (cmd.w1)
                    begin
                        next_we = 1'b1; next_wa = head_reg; next_wd = fh_reg;
                    end
                    fh_next  = head_reg;
                    cnt_next = cnt_dec;
                end
            end
            OP_DEL_LAST:
            begin
                if (tail_reg != NIL)
                begin
                    if (cur_reg == tail_reg)
                        cur_next = NIL;
                    if (tail_reg == head_reg)
                    begin
                        head_next = NIL;
                        tail_next = NIL;
                    end
                    else
                    begin
                        tail_next = d1_prev_reg;
                        if (cmd.w1)
                        begin
                            next_we = 1'b1; next_wa = d1_prev_reg; next_wd = NIL;
                        end
                    end
                    if (cmd.w2)
                    begin
                        next_we = 1'b1; next_wa = tail_reg; next_wd = fh_reg;
                    end
                    fh_next  = tail_reg;
                    cnt_next = cnt_dec;
                end
            end
            OP_DEL_AFTER:
            begin
                if (!c_nil && (d1_next_reg != NIL))
                begin
                    if (cmd.w1)
                    begin
                        next_we = 1'b1; next_wa = cur_reg; next_wd = d2_next_reg;
                    end
                    if (d1_next_reg == tail_reg)
                        tail_next = cur_reg;
                    else if (cmd.w1)
                    begin
                        prev_we = 1'b1; prev_wa = d2_next_reg; prev_wd = cur_reg;
                    end
                    if (cmd.w2)
                    begin
                        next_we = 1'b1; next_wa = d1_next_reg; next_wd = fh_reg;
                    end
                    fh_next  = d1_next_reg;
                    cnt_next = cnt_dec;
                end
            end
            OP_DEL_BEFORE:
            begin
                if (!c_nil && (d1_prev_reg != NIL))
                begin
                    if (cmd.w1)
                    begin
                        prev_we = 1'b1; prev_wa = cur_reg; prev_wd = d2_prev_reg;
                    end
                    if (d1_prev_reg == head_reg)
                        head_next = cur_reg;
                    else if (cmd.w1)
                    begin
                        next_we = 1'b1; next_wa = d2_prev_reg; next_wd = cur_reg;
                    end
                    if (cmd.w2)
                    begin
                        next_we = 1'b1; next_wa = d1_prev_reg; next_wd = fh_reg;
                    end
                    fh_next  = d1_prev_reg;
                    cnt_next = cnt_dec;
                end
            end
            OP_INS_AFTER:
            begin
                if (!c_nil)
                begin
                    if (full)
                        st = ST_FULL;
                    else
                    begin
                        if (cmd.w1)
                        begin
                            val_we  = 1'b1; val_wa  = fh_reg;
                            next_we = 1'b1; next_wa = fh_reg; next_wd = d2_next_reg;
                            prev_we = 1'b1; prev_wa = fh_reg; prev_wd = cur_reg;
                        end
                        if (cmd.w2)
                        begin
                            next_we = 1'b1; next_wa = cur_reg; next_wd = fh_reg;
                        end
                        if (cur_reg == tail_reg)
                            tail_next = fh_reg;
                        else if (cmd.w2)
                        begin
                            prev_we = 1'b1; prev_wa = d2_next_reg; prev_wd = fh_reg;
                        end
                        fh_next  = d1_next_reg;
                        cnt_next = cnt_reg + ONE;
                    end
                end
            end
            OP_INS_BEFORE:
            begin
                if (!c_nil)
                begin
                    if (full)
                        st = ST_FULL;
                    else
                    begin
                        if (cmd.w1)
                        begin
                            val_we  = 1'b1; val_wa  = fh_reg;
                            prev_we = 1'b1; prev_wa = fh_reg; prev_wd = d2_prev_reg;
                            next_we = 1'b1; next_wa = fh_reg; next_wd = cur_reg;
                        end
                        if (cmd.w2)
                        begin
                            prev_we = 1'b1; prev_wa = cur_reg; prev_wd = fh_reg;
                        end
                        if (cur_reg == head_reg)
                            head_next = fh_reg;
                        else if (cmd.w2)
                        begin
                            next_we = 1'b1; next_wa = d2_prev_reg; next_wd = fh_reg;
                        end
                        fh_next  = d1_next_reg;
                        cnt_next = cnt_reg + ONE;
                    end
                end
            end
            OP_WR_CUR:
            begin
                if (!c_nil && cmd.w1)
                begin
                    val_we = 1'b1; val_wa = cur_reg;
                end
            end
            OP_STEP_FWD:  if (!c_nil) cur_next = d1_next_reg;
            OP_STEP_BACK: if (!c_nil) cur_next = d1_prev_reg;
            default:      st = ST_OK;
        endcase
        // The sweep rebuilds the free chain in index order.
        if (cmd.sweep)
        begin
            next_we = 1'b1;
            next_wa = sweep_idx;
            next_wd = sweep_idx + ONE;
        end
    end

    // Request word and captured read data.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= req.req_type;
            v_reg  <= req.value;
        end
        if (cmd.rd2)
        begin
            d1_next_reg <= rd_next;
            d1_prev_reg <= rd_prev;
            d1_val_reg  <= rd_val;
        end
        if (cmd.cap)
        begin
            d2_next_reg <= rd_next;
            d2_prev_reg <= rd_prev;
        end
        if (cmd.w2)
        begin
            result_reg.read_value    <= rv;
            result_reg.status        <= st;
            result_reg.cursor_active <= (cur_next != NIL);
            result_reg.element_count <= COUNT_W'(cnt_next);
        end
        else if (cmd.clear_done)
        begin
            result_reg <= '0;
        end
    end

    // List pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= NIL;
            tail_reg <= NIL;
            cur_reg  <= NIL;
            fh_reg   <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.sweep)
        begin
            head_reg <= NIL;
            tail_reg <= NIL;
            cur_reg  <= NIL;
            fh_reg   <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.w2)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cur_reg  <= cur_next;
            fh_reg   <= fh_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

/* sv/doubly_linked_list_with_cursor_core.sv */
// Top level of the doubly linked list core with cursor.
// Depends on dllc_pkg, dllc_ctrl and dllc_datapath.
//
//  Channel   Handshake           Word
//  request   start, busy         req (req_type, value)
//  result    done strobe         result (read_value, status, cursor_active,
//                                        element_count)
//
// A request is taken when start is high and busy is low. Every request except
// clear steps through RD1, RD2, CAP, W1 and W2 (two pool reads, a capture, two
// write steps) and its result is strobed on done in the first cycle with busy
// low again. Clear sweeps the next-link memory one entry a cycle. After reset
// the same sweep runs with busy high and gives no result. The receiver cannot
// stall: each result is strobed on done for one cycle.
`timescale 1ns / 1ps
`default_nettype none

module doubly_linked_list_with_cursor_core
    import dllc_pkg::*;
#(
    parameter int POOL_DEPTH = 256
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  req_t      req,
    output logic      done,
    output rsp_t      result
);

    localparam int IW = $clog2(POOL_DEPTH + 1);

    cmd_t          cmd;
    sts_t          sts;
    logic [IW-1:0] sweep_idx;

    // Phase sequencer.
    dllc_ctrl #(
        .POOL_DEPTH(POOL_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .sts      (sts),
        .cmd      (cmd),
        .sweep_idx(sweep_idx),
        .busy     (busy),
        .done     (done)
    );

    // Pool memories and list pointers.
    dllc_datapath #(
        .POOL_DEPTH(POOL_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .sweep_idx(sweep_idx),
        .sts      (sts),
        .result   (result)
    );

endmodule

`default_nettype wire

/* sv/dllc_checker.sv */
// Port-level checker for the doubly linked list core, bound to the top level.
// Depends on dllc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "doubly_linked_list_with_cursor_core_assert.svh"

module dllc_checker
    import dllc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input rsp_t      result
);

    // A taken request keeps the core busy in the next cycle.
    `DLLC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // A result word only follows a busy cycle.
    `DLLC_ASSERT_NOW(a_done_after_busy, clk, rst_n, done, $past(busy))

    // A result never carries a status code above pool full.
    `DLLC_ASSERT_NOW(a_status_code, clk, rst_n, done, result.status <= ST_FULL)

endmodule

bind doubly_linked_list_with_cursor_core dllc_checker u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .result(result)
);

`default_nettype wire

/* bench/doubly_linked_list_with_cursor_core_tb.sv */
// Testbench for the doubly linked list core: drives list requests and checks
// every result word against a behavioural model of the list. Depends on dllc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module doubly_linked_list_with_cursor_core_tb;
    import dllc_pkg::*;

    localparam int DEPTH = 256;
    localparam int NUL   = DEPTH;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t result;

    doubly_linked_list_with_cursor_core #(.POOL_DEPTH(DEPTH)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .done(done),
        .result(result)
    );

    // Model state of the list.
    logic [31:0] mdl_val [DEPTH];
    int          mdl_next [DEPTH];
    int          mdl_prev [DEPTH];
    int          mdl_head;
    int          mdl_tail;
    int          mdl_cur;
    int          mdl_free;
    int          mdl_count;

    req_t pending_words [$];
    rsp_t expected_words [$];
    int   fail_count;
    int   idle_pct;
    bit   stim_done;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Rebuild the free chain and empty the list.
    function automatic void list_clear();
        for (int i = 0; i < DEPTH; i++)
        begin
            mdl_next[i] = i + 1;
        end
        mdl_head = NUL;
        mdl_tail = NUL;
        mdl_cur = NUL;
        mdl_free = 0;
        mdl_count = 0;
    endfunction

    function automatic int take_node(logic [31:0] v);
        int n;
        n = mdl_free;
        if (n >= NUL)
        begin
            return NUL;
        end
        mdl_free = mdl_next[n];
        mdl_val[n] = v;
        mdl_count++;
        return n;
    endfunction

    function automatic void give_node(int n);
        if (n >= NUL)
        begin
            return;
        end
        mdl_next[n] = mdl_free;
        mdl_free = n;
        if (mdl_count > 0)
        begin
            mdl_count--;
        end
    endfunction

    // Apply one request to the model and return the result word it gives.
    function automatic rsp_t list_apply(req_t r);
        rsp_t o;
        int c;
        int n;
        int m;
        o = '0;
        c = mdl_cur;
        case (r.req_type)
            OP_CLEAR: list_clear();
            OP_INS_FIRST:
            begin
                n = take_node(r.value);
                if (n == NUL)
                begin
                    o.status = ST_FULL;
                end
                else
                begin
                    mdl_prev[n] = NUL;
                    mdl_next[n] = mdl_head;
                    if (mdl_head != NUL) mdl_prev[mdl_head] = n;
                    else mdl_tail = n;
                    mdl_head = n;
                end
            end
            OP_INS_LAST:
            begin
                n = take_node(r.value);
                if (n == NUL)
                begin
                    o.status = ST_FULL;
                end
                else
                begin
                    mdl_next[n] = NUL;
                    mdl_prev[n] = mdl_tail;
                    if (mdl_tail != NUL) mdl_next[mdl_tail] = n;
                    else mdl_head = n;
                    mdl_tail = n;
                end
            end
            OP_CUR_FIRST: mdl_cur = mdl_head;
            OP_CUR_LAST: mdl_cur = mdl_tail;
            OP_RD_FIRST:
                if (mdl_head == NUL) o.status = ST_EMPTY;
                else o.read_value = mdl_val[mdl_head];
            OP_RD_LAST:
                if (mdl_tail == NUL) o.status = ST_EMPTY;
                else o.read_value = mdl_val[mdl_tail];
            OP_DEL_FIRST:
            begin
                n = mdl_head;
                if (n != NUL)
                begin
                    if (c == n) mdl_cur = NUL;
                    if (n == mdl_tail)
                    begin
                        mdl_head = NUL;
                        mdl_tail = NUL;
                    end
                    else
                    begin
                        mdl_head = mdl_next[n];
                        if (mdl_head < NUL) mdl_prev[mdl_head] = NUL;
                    end
                    give_node(n);
                end
            end
            OP_DEL_LAST:
            begin
                n = mdl_tail;
                if (n != NUL)
                begin
                    if (c == n) mdl_cur = NUL;
                    if (n == mdl_head)
                    begin
                        mdl_head = NUL;
                        mdl_tail = NUL;
                    end
                    else
                    begin
                        mdl_tail = mdl_prev[n];
                        if (mdl_tail < NUL) mdl_next[mdl_tail] = NUL;
                    end
                    give_node(n);
                end
            end
            OP_DEL_AFTER:
                if (c != NUL && mdl_next[c] != NUL)
                begin
                    n = mdl_next[c];
                    m = mdl_next[n];
                    mdl_next[c] = m;
                    if (n == mdl_tail) mdl_tail = c;
                    else if (m < NUL) mdl_prev[m] = c;
                    give_node(n);
                end
            OP_DEL_BEFORE:
                if (c != NUL && mdl_prev[c] != NUL)
                begin
                    n = mdl_prev[c];
                    m = mdl_prev[n];
                    mdl_prev[c] = m;
                    if (n == mdl_head) mdl_head = c;
                    else if (m < NUL) mdl_next[m] = c;
                    give_node(n);
                end
            OP_INS_AFTER:
                if (c != NUL)
                begin
                    n = take_node(r.value);
                    if (n == NUL)
                    begin
                        o.status = ST_FULL;
                    end
                    else
                    begin
                        m = mdl_next[c];
                        mdl_next[n] = m;
                        mdl_prev[n] = c;
                        mdl_next[c] = n;
                        if (c == mdl_tail) mdl_tail = n;
                        else if (m < NUL) mdl_prev[m] = n;
                    end
                end
            OP_INS_BEFORE:
                if (c != NUL)
                begin
                    n = take_node(r.value);
                    if (n == NUL)
                    begin
                        o.status = ST_FULL;
                    end
                    else
                    begin
                        m = mdl_prev[c];
                        mdl_prev[n] = m;
                        mdl_next[n] = c;
                        mdl_prev[c] = n;
                        if (c == mdl_head) mdl_head = n;
                        else if (m < NUL) mdl_next[m] = n;
                    end
                end
            OP_RD_CUR:
                if (c == NUL) o.status = ST_EMPTY;
                else o.read_value = mdl_val[c];
            OP_WR_CUR: if (c != NUL) mdl_val[c] = r.value;
            OP_STEP_FWD: if (c != NUL) mdl_cur = mdl_next[c];
            OP_STEP_BACK: if (c != NUL) mdl_cur = mdl_prev[c];
            default: ;
        endcase
        o.cursor_active = (mdl_cur != NUL);
        o.element_count = mdl_count[COUNT_W-1:0];
        return o;
    endfunction

    function automatic void add_word(logic [4:0] op, logic [31:0] v);
        req_t r;
        r.req_type = op;
        r.value = v;
        pending_words.push_back(r);
    endfunction

    // Random operation weighted towards list building and cursor work.
    function automatic logic [4:0] pick_op(int fill_bias);
        int k;
        k = $urandom_range(99);
        if (k < fill_bias) return ($urandom_range(1)) ? OP_INS_LAST : OP_INS_FIRST;
        if (k < fill_bias + 4) return ($urandom_range(1)) ? OP_INS_AFTER : OP_INS_BEFORE;
        if (k < 98) return 5'($urandom_range(16, 1));
        if (k == 98) return OP_CLEAR;
        return 5'($urandom_range(31, 17));
    endfunction

    // Request driver: takes words from the pending queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req <= '0;
        end
        else if (start && !busy)
        begin
            expected_words.push_back(list_apply(req));
            if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                req <= pending_words.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
        else if (!start && pending_words.size() > 0 && $urandom_range(99) >= idle_pct)
        begin
            req <= pending_words.pop_front();
            start <= 1'b1;
        end
    end

    // Result monitor: compares each strobed word with the oldest expectation.
    always @(posedge clk)
    begin
        rsp_t exp_w;
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, result);
                fail_count++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (result.read_value !== exp_w.read_value)
                begin
                    $display("%0t: read_value expected %0d actual %0d", $time,
                             exp_w.read_value, result.read_value);
                    fail_count++;
                end
                if (result.status !== exp_w.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_w.status, result.status);
                    fail_count++;
                end
                if (result.cursor_active !== exp_w.cursor_active)
                begin
                    $display("%0t: cursor_active expected %0d actual %0d", $time,
                             exp_w.cursor_active, result.cursor_active);
                    fail_count++;
                end
                if (result.element_count !== exp_w.element_count)
                begin
                    $display("%0t: element_count expected %0d actual %0d", $time,
                             exp_w.element_count, result.element_count);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int bias;
        fail_count = 0;
        idle_pct = 32;
        stim_done = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            mdl_val[i] = '0;
            mdl_prev[i] = 0;
        end
        list_clear();
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reads and cursor work on an empty list, then basic edits.
        add_word(OP_RD_FIRST, 32'd0);
        add_word(OP_RD_LAST, 32'd0);
        add_word(OP_RD_CUR, 32'd0);
        add_word(OP_DEL_FIRST, 32'd0);
        add_word(OP_DEL_LAST, 32'd0);
        add_word(OP_INS_AFTER, 32'd5);
        add_word(OP_STEP_FWD, 32'd0);
        add_word(OP_INS_FIRST, 32'h8000_0000);
        add_word(OP_INS_LAST, 32'h7fff_ffff);
        add_word(OP_CUR_FIRST, 32'd0);
        add_word(OP_INS_AFTER, 32'hffff_ffff);
        add_word(OP_INS_BEFORE, 32'd0);
        add_word(OP_WR_CUR, 32'h5555_aaaa);
        add_word(OP_RD_CUR, 32'd0);
        add_word(OP_STEP_BACK, 32'd0);
        add_word(OP_STEP_BACK, 32'd0);
        add_word(OP_CUR_LAST, 32'd0);
        add_word(OP_DEL_BEFORE, 32'd0);
        add_word(OP_DEL_AFTER, 32'd0);
        add_word(OP_DEL_LAST, 32'd0);
        add_word(OP_RD_FIRST, 32'd0);
        add_word(OP_RD_LAST, 32'd0);
        add_word(5'd31, 32'd0);
        add_word(5'd17, 32'd0);
        add_word(OP_CLEAR, 32'd0);

        // Fill the pool past full, then probe the full case at both ends.
        for (int i = 0; i < DEPTH + 2; i++)
        begin
            add_word(OP_INS_LAST, $urandom());
        end
        add_word(OP_CUR_FIRST, 32'd0);
        add_word(OP_INS_AFTER, 32'd1);
        add_word(OP_INS_BEFORE, 32'd1);
        add_word(OP_INS_FIRST, 32'd1);
        add_word(OP_STEP_FWD, 32'd0);
        add_word(OP_DEL_BEFORE, 32'd0);
        add_word(OP_CLEAR, 32'd0);

        // Random phases, the fourth one without idling.
        for (int p = 0; p < 6; p++)
        begin
            while (pending_words.size() > 20) @(posedge clk);
            idle_pct = (p == 3) ? 0 : 32;
            bias = (p % 2 == 0) ? 45 : 20;
            for (int i = 0; i < 240; i++)
            begin
                add_word(pick_op(bias), $urandom());
            end
        end
        stim_done = 1;
        while (pending_words.size() > 0 || start || expected_words.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #100ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+sv
sv/dllc_pkg.sv
sv/dllc_ctrl.sv
sv/dllc_datapath.sv
sv/doubly_linked_list_with_cursor_core.sv
sv/dllc_checker.sv
bench/doubly_linked_list_with_cursor_core_tb.sv
